/* sv/ptsr_pkg.sv */
// Package for the point translate/scale/rotate block: types, constants,
// CORDIC arctangent table and fixed-point helpers. No dependencies.
package ptsr_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBits    = 16;
  localparam int CordicSteps = 20;
  localparam int TrigFrac    = 30;
  localparam int StepW       = 5;
  // compare/subtract passes of 360 * 2^k, k from ModSteps-1 down to 0
  localparam int ModSteps    = 8;

  localparam logic signed [32:0] GainQ30 = 33'sd652032874;
  localparam logic signed [47:0] FullTurn = 48'sd360 <<< FracBits;
  localparam logic signed [47:0] HalfTurn = 48'sd180 <<< FracBits;
  localparam logic signed [47:0] QuarterTurn = 48'sd90 <<< FracBits;
  // 128 full turns: lifts any 32-bit angle to a nonnegative value below 256 turns
  localparam logic signed [47:0] TurnBias = 48'sd46080 <<< FracBits;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_SCALE  = 2'd2,
    OP_ROTATE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_REDUCE,
    ST_MOD,
    ST_FOLD,
    ST_CORDIC,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  // arctangent of 2^-i in units of 2^-24 degree
  function automatic logic signed [31:0] atan_step(input logic [StepW-1:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'sd754974720;
      5'd1:  r = 32'sd445687602;
      5'd2:  r = 32'sd235489088;
      5'd3:  r = 32'sd119537938;
      5'd4:  r = 32'sd60000934;
      5'd5:  r = 32'sd30029717;
      5'd6:  r = 32'sd15018523;
      5'd7:  r = 32'sd7509720;
      5'd8:  r = 32'sd3754917;
      5'd9:  r = 32'sd1877466;
      5'd10: r = 32'sd938734;
      5'd11: r = 32'sd469367;
      5'd12: r = 32'sd234684;
      5'd13: r = 32'sd117342;
      5'd14: r = 32'sd58671;
      5'd15: r = 32'sd29335;
      5'd16: r = 32'sd14668;
      5'd17: r = 32'sd7334;
      5'd18: r = 32'sd3667;
      5'd19: r = 32'sd1833;
      default: r = 32'sd917;
    endcase
    return r;
  endfunction

endpackage

/* sv/point_translate_scale_rotate.sv */
// Top level of the point translate/scale/rotate block.
// Depends on ptsr_pkg; one shared 33x33 multiplier and one CORDIC datapath.
// Load/move go straight to the done state; scale forms three products, then rounds;
// rotate runs per axis: reduce, mod passes, fold, CORDIC steps, four products, sum.
// One request at a time; the next is accepted only after the result has been taken;
// per axis, 8 angle reduction passes and 20 CORDIC steps set the rotate time.
// Result is held in an output register until taken; a new request is accepted
// only once that register is empty and the sequencer is idle.
// Reset (rst_n low, synchronous) clears the point to zero and the handshake state.
module point_translate_scale_rotate (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // op
  input  logic [95:0]  in_tdata,   // first_value, second_value, third_value
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,  // saturated
  output logic [95:0]  out_tdata   // x_out, y_out, z_out
);
  import ptsr_pkg::*;

  localparam logic signed [31:0] MaxC = 32'sh7FFFFFFF;
  localparam logic signed [31:0] MinC = 32'sh80000000;

  state_t state_r, state_nxt;
  logic signed [31:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [31:0] v_r [3];
  logic [1:0] axis_r, axis_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic sat_r, sat_nxt;
  logic neg_r, neg_nxt;
  logic signed [47:0] ang_r, ang_nxt;
  logic signed [33:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [33:0] cs_r, sn_r, cs_nxt, sn_nxt;
  logic signed [66:0] prod_r [4];
  logic signed [66:0] prod_nxt;
  logic [95:0] odata_r;
  logic osat_r, ovalid_r;

  // shared multiplier operands
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  // round half up at s bits and saturate to 32 bits
  function automatic logic signed [32:0] rsat(input logic signed [67:0] w, input int s);
    logic signed [67:0] t;
    t = (w + (68'sd1 <<< (s - 1))) >>> s;
    if (t > 68'sd2147483647) return {1'b1, MaxC};
    if (t < -68'sd2147483648) return {1'b1, MinC};
    return {1'b0, t[31:0]};
  endfunction

  logic signed [32:0] r_a, r_b;
  logic signed [31:0] pa, pb;
  logic signed [47:0] rem;
  logic signed [32:0] addx, addy, addz;
  logic signed [33:0] xs, ys;

  assign in_tready = (state_r == ST_IDLE) && !ovalid_r;

  // operand pair for the axis in work: (y,z), (x,z), (x,y)
  always_comb begin
    unique case (axis_r)
      2'd0:    begin pa = py_r; pb = pz_r; end
      2'd1:    begin pa = px_r; pb = pz_r; end
      default: begin pa = px_r; pb = py_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      px_r <= '0; py_r <= '0; pz_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
      if (state_r == ST_DONE) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt; step_r <= step_nxt; phase_r <= phase_nxt;
    sat_r <= sat_nxt; neg_r <= neg_nxt; ang_r <= ang_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cs_r <= cs_nxt; sn_r <= sn_nxt;
    if (state_r == ST_IDLE && in_tvalid && in_tready) begin
      v_r[0] <= in_tdata[31:0];
      v_r[1] <= in_tdata[63:32];
      v_r[2] <= in_tdata[95:64];
    end
    if (state_r == ST_SCALE || state_r == ST_MUL) prod_r[phase_r] <= prod_nxt;
    if (state_r == ST_DONE) begin
      odata_r <= {pz_r, py_r, px_r};
      osat_r  <= sat_r;
    end
  end

  // sequencer and shared datapath
  always_comb begin
    state_nxt = state_r;
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    axis_nxt = axis_r; step_nxt = step_r; phase_nxt = phase_r;
    sat_nxt = sat_r; neg_nxt = neg_r; ang_nxt = ang_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cs_nxt = cs_r; sn_nxt = sn_r;
    ma = '0; mb = '0;
    prod_nxt = '0;
    r_a = '0; r_b = '0; rem = '0;
    addx = '0; addy = '0; addz = '0;
    xs = '0; ys = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          sat_nxt = 1'b0; phase_nxt = '0; axis_nxt = '0;
          unique case (op_t'(in_tuser))
            OP_LOAD: begin
              px_nxt = in_tdata[31:0]; py_nxt = in_tdata[63:32];
              pz_nxt = in_tdata[95:64];
              state_nxt = ST_DONE;
            end
            OP_MOVE: begin
              addx = 33'(px_r) + 33'(signed'(in_tdata[31:0]));
              addy = 33'(py_r) + 33'(signed'(in_tdata[63:32]));
              addz = 33'(pz_r) + 33'(signed'(in_tdata[95:64]));
              px_nxt = (addx[32] != addx[31]) ? (addx[32] ? MinC : MaxC) : addx[31:0];
              py_nxt = (addy[32] != addy[31]) ? (addy[32] ? MinC : MaxC) : addy[31:0];
              pz_nxt = (addz[32] != addz[31]) ? (addz[32] ? MinC : MaxC) : addz[31:0];
              sat_nxt = (addx[32] != addx[31]) || (addy[32] != addy[31]) ||
                        (addz[32] != addz[31]);
              state_nxt = ST_DONE;
            end
            OP_SCALE:  state_nxt = ST_SCALE;
            default:   state_nxt = ST_REDUCE;
          endcase
        end
      end
      // one axis product per cycle, then round and saturate all three
      ST_SCALE: begin
        unique case (phase_r)
          2'd0:    begin ma = 33'(px_r); mb = 33'(v_r[0]); end
          2'd1:    begin ma = 33'(py_r); mb = 33'(v_r[1]); end
          default: begin ma = 33'(pz_r); mb = 33'(v_r[2]); end
        endcase
        prod_nxt = 67'(mp);
        if (phase_r == 2'd3) begin
          r_a = rsat(68'(prod_r[0]), FracBits); px_nxt = r_a[31:0];
          r_b = rsat(68'(prod_r[1]), FracBits); py_nxt = r_b[31:0];
          sat_nxt = r_a[32] | r_b[32];
          r_a = rsat(68'(prod_r[2]), FracBits); pz_nxt = r_a[31:0];
          sat_nxt = sat_nxt | r_a[32];
          state_nxt = ST_DONE;
        end
        phase_nxt = phase_r + 2'd1;
      end
      // bias the angle by whole turns so it is nonnegative
      ST_REDUCE: begin
        ang_nxt = 48'(v_r[axis_r]) + TurnBias;
        step_nxt = StepW'(ModSteps - 1);
        state_nxt = ST_MOD;
      end
      // angle mod 360 by compare/subtract of 360 * 2^k, one k per cycle
      ST_MOD: begin
        rem = FullTurn <<< step_r;
        if (ang_r >= rem) ang_nxt = ang_r - rem;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = ST_FOLD;
      end
      // into (-180,180], then fold into [-90,90]
      ST_FOLD: begin
        rem = ang_r;
        if (rem > HalfTurn) rem = rem - FullTurn;
        neg_nxt = 1'b0;
        if (rem > QuarterTurn) begin rem = rem - HalfTurn; neg_nxt = 1'b1; end
        else if (rem < -QuarterTurn) begin rem = rem + HalfTurn; neg_nxt = 1'b1; end
        ang_nxt = rem <<< (24 - FracBits);
        cx_nxt = 34'(GainQ30); cy_nxt = '0; step_nxt = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        xs = cx_r >>> step_r; ys = cy_r >>> step_r;
        if (ang_r >= 0) begin
          cx_nxt = cx_r - ys; cy_nxt = cy_r + xs; ang_nxt = ang_r - 48'(atan_step(step_r));
        end else begin
          cx_nxt = cx_r + ys; cy_nxt = cy_r - xs; ang_nxt = ang_r + 48'(atan_step(step_r));
        end
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(CordicSteps - 1)) begin
          cs_nxt = neg_r ? -cx_nxt : cx_nxt;
          sn_nxt = neg_r ? -cy_nxt : cy_nxt;
          phase_nxt = '0;
          state_nxt = ST_MUL;
        end
      end
      // a*c, b*s, a*s, b*c in turn through the shared multiplier
      ST_MUL: begin
        unique case (phase_r)
          2'd0:    begin ma = 33'(pa); mb = cs_r[32:0]; end
          2'd1:    begin ma = 33'(pb); mb = sn_r[32:0]; end
          2'd2:    begin ma = 33'(pa); mb = sn_r[32:0]; end
          default: begin ma = 33'(pb); mb = cs_r[32:0]; end
        endcase
        prod_nxt = 67'(mp);
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd3) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        r_a = rsat(68'(prod_r[0]) + 68'(prod_r[1]), TrigFrac);
        r_b = rsat(68'(prod_r[3]) - 68'(prod_r[2]), TrigFrac);
        sat_nxt = sat_r | r_a[32] | r_b[32];
        unique case (axis_r)
          2'd0:    begin py_nxt = r_a[31:0]; pz_nxt = r_b[31:0]; end
          2'd1:    begin px_nxt = r_a[31:0]; pz_nxt = r_b[31:0]; end
          default: begin px_nxt = r_a[31:0]; py_nxt = r_b[31:0]; end
        endcase
        axis_nxt = axis_r + 2'd1;
        state_nxt = (axis_r == 2'd2) ? ST_DONE : ST_REDUCE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = osat_r;

  // no request taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");
  // result is valid in the cycle after the sequencer's done state
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |=> out_tvalid) else $error("result lost");
  // CORDIC step counter stays in range
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CORDIC |-> step_r < StepW'(CordicSteps)) else $error("step overrun");
endmodule
